// ===== hw/rtl/sieve_prime_sum_unit_macros.svh =====
// Assertion macros used by the checker file of the sieve prime sum unit.
`ifndef SIEVE_PRIME_SUM_UNIT_MACROS_SVH
`define SIEVE_PRIME_SUM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sieve prime sum unit: assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sieve prime sum unit: assertion failed");

`endif

// ===== hw/rtl/sps_pkg.sv =====
package sps_pkg;

    // Largest supported limit and the derived bitmap and counter widths.
    localparam int MAX_LIMIT = 65535;
    localparam int MAP_DEPTH = MAX_LIMIT + 1;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int IN_W      = 16;
    localparam int SUM_W     = 32;

    // Program steps of the sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SIEVE_INIT,
        ST_TEST,
        ST_CHECK,
        ST_MARK,
        ST_NEXT,
        ST_SUM_INIT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_RESULT
    } t_step;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_J_GE_LIM,
        C_SQ_GT_LIM,
        C_RD_SET,
        C_J_GT_LIM,
        C_I_GT_LIM,
        C_OUT_FREE
    } t_cond;

    // Which outcome of the condition enables the gated operations.
    typedef enum logic [1:0] {
        G_ALL,
        G_TRUE,
        G_FALSE
    } t_gate;

    typedef enum logic [2:0] {
        J_HOLD,
        J_CLR,
        J_INC,
        J_SQ,
        J_ADD_I
    } t_jop;

    typedef enum logic [1:0] {
        I_HOLD,
        I_TWO,
        I_NEXT
    } t_iop;

    typedef enum logic [1:0] {
        S_HOLD,
        S_CLR,
        S_ADD_PRIME
    } t_sop;

    typedef enum logic {
        A_J,
        A_I
    } t_asel;

    // One control word of the program.
    typedef struct packed {
        t_cond cond;
        t_gate gate;
        t_step tgt_t;
        t_step tgt_f;
        logic  in_rdy;
        t_jop  jop;
        t_iop  iop;
        t_sop  sop;
        t_asel asel;
        logic  mem_we;
        logic  mem_wd;
        logic  lim_ld;
        logic  out_ld;
    } t_ctrl;

    // Datapath status used for branching.
    typedef struct packed {
        logic in_valid;
        logic j_ge_lim;
        logic sq_gt_lim;
        logic rd_set;
        logic j_gt_lim;
        logic i_gt_lim;
        logic out_free;
    } t_flags;

    // Program ROM: one control word per step.
    function automatic t_ctrl sps_rom(input t_step step);
        t_ctrl w;
        w = '{cond: C_ALWAYS, gate: G_ALL, tgt_t: ST_IDLE, tgt_f: ST_IDLE,
              in_rdy: 1'b0, jop: J_HOLD, iop: I_HOLD, sop: S_HOLD, asel: A_J,
              mem_we: 1'b0, mem_wd: 1'b0, lim_ld: 1'b0, out_ld: 1'b0};
        case (step)
            ST_IDLE: begin
                w.cond   = C_IN_VALID;
                w.gate   = G_TRUE;
                w.tgt_t  = ST_CLEAR;
                w.tgt_f  = ST_IDLE;
                w.in_rdy = 1'b1;
                w.jop    = J_CLR;
                w.lim_ld = 1'b1;
            end
            ST_CLEAR: begin
                w.cond   = C_J_GE_LIM;
                w.tgt_t  = ST_SIEVE_INIT;
                w.tgt_f  = ST_CLEAR;
                w.jop    = J_INC;
                w.asel   = A_J;
                w.mem_we = 1'b1;
                w.mem_wd = 1'b0;
            end
            ST_SIEVE_INIT: begin
                w.tgt_t = ST_TEST;
                w.tgt_f = ST_TEST;
                w.iop   = I_TWO;
            end
            ST_TEST: begin
                w.cond  = C_SQ_GT_LIM;
                w.tgt_t = ST_SUM_INIT;
                w.tgt_f = ST_CHECK;
                w.asel  = A_I;
            end
            ST_CHECK: begin
                w.cond  = C_RD_SET;
                w.tgt_t = ST_NEXT;
                w.tgt_f = ST_MARK;
                w.jop   = J_SQ;
            end
            ST_MARK: begin
                w.cond   = C_J_GT_LIM;
                w.gate   = G_FALSE;
                w.tgt_t  = ST_NEXT;
                w.tgt_f  = ST_MARK;
                w.jop    = J_ADD_I;
                w.asel   = A_J;
                w.mem_we = 1'b1;
                w.mem_wd = 1'b1;
            end
            ST_NEXT: begin
                w.tgt_t = ST_TEST;
                w.tgt_f = ST_TEST;
                w.iop   = I_NEXT;
            end
            ST_SUM_INIT: begin
                w.tgt_t = ST_SUM_RD;
                w.tgt_f = ST_SUM_RD;
                w.iop   = I_TWO;
                w.sop   = S_CLR;
            end
            ST_SUM_RD: begin
                w.cond  = C_I_GT_LIM;
                w.tgt_t = ST_RESULT;
                w.tgt_f = ST_SUM_ACC;
                w.asel  = A_I;
            end
            ST_SUM_ACC: begin
                w.tgt_t = ST_SUM_RD;
                w.tgt_f = ST_SUM_RD;
                w.iop   = I_NEXT;
                w.sop   = S_ADD_PRIME;
            end
            ST_RESULT: begin
                w.cond   = C_OUT_FREE;
                w.gate   = G_TRUE;
                w.tgt_t  = ST_IDLE;
                w.tgt_f  = ST_RESULT;
                w.out_ld = 1'b1;
            end
            default: begin
                w.tgt_t = ST_IDLE;
                w.tgt_f = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/sps_sequencer.sv =====
module sps_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sps_pkg::t_flags i_flags,
    output sps_pkg::t_ctrl  o_ctrl
);
    import sps_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl w;
    logic  cond_hit;
    logic  en;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Fetch the control word, evaluate its condition and pick the next step.
    always_comb begin
        w = sps_rom(r_step);
        case (w.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_IN_VALID:  cond_hit = i_flags.in_valid;
            C_J_GE_LIM:  cond_hit = i_flags.j_ge_lim;
            C_SQ_GT_LIM: cond_hit = i_flags.sq_gt_lim;
            C_RD_SET:    cond_hit = i_flags.rd_set;
            C_J_GT_LIM:  cond_hit = i_flags.j_gt_lim;
            C_I_GT_LIM:  cond_hit = i_flags.i_gt_lim;
            C_OUT_FREE:  cond_hit = i_flags.out_free;
            default:     cond_hit = 1'b0;
        endcase

        case (w.gate)
            G_TRUE:  en = cond_hit;
            G_FALSE: en = !cond_hit;
            default: en = 1'b1;
        endcase

        n_step = cond_hit ? w.tgt_t : w.tgt_f;

        // Gated operations only take effect when the gate allows them.
        o_ctrl        = w;
        o_ctrl.mem_we = w.mem_we & en;
        o_ctrl.lim_ld = w.lim_ld & en;
        o_ctrl.out_ld = w.out_ld & en;
        o_ctrl.jop    = en ? w.jop : J_HOLD;
    end

endmodule

// ===== hw/rtl/sieve_prime_sum_unit.sv =====
// Sieve prime sum unit: sum of all primes up to a requested limit n, one transaction at a time.
// The sequencer clears the bitmap from 0 to n, then tests each candidate i from 2 to floor(sqrt(n))
// and strikes out the multiples of each prime i from i*i up to n, then sums the candidates from 2 to n
// that are not struck out; the one-access-per-cycle bitmap sets the pace of these loops.
// The next transaction can be taken in the cycle after the result is loaded, even while it waits.
// Reset is synchronous, active low, and returns the sequencer to idle with no result pending.
module sieve_prime_sum_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [sps_pkg::IN_W-1:0] i_upper_limit,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [sps_pkg::SUM_W-1:0] o_prime_sum
);
    import sps_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;

    logic [ADDR_W-1:0] r_lim;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_sq;
    logic [CNT_W-1:0]  r_j;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_valid;
    logic              r_rd;
    logic [ADDR_W-1:0] lim_sat;
    logic [ADDR_W-1:0] mem_addr;
    logic [CNT_W-1:0]  lim_ext;

    logic map_mem [MAP_DEPTH];

    sps_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // Limits above the bitmap size saturate.
    always_comb begin
        if (32'(i_upper_limit) > 32'(MAX_LIMIT)) begin
            lim_sat = ADDR_W'(MAX_LIMIT);
        end else begin
            lim_sat = ADDR_W'(i_upper_limit);
        end
    end

    assign lim_ext  = {1'b0, r_lim};
    assign mem_addr = (ctrl.asel == A_I) ? r_i[ADDR_W-1:0] : r_j[ADDR_W-1:0];

    // Status flags for the sequencer.
    always_comb begin
        flags.in_valid  = i_valid;
        flags.j_ge_lim  = r_j >= lim_ext;
        flags.sq_gt_lim = r_sq > lim_ext;
        flags.rd_set    = r_rd;
        flags.j_gt_lim  = r_j > lim_ext;
        flags.i_gt_lim  = r_i > lim_ext;
        flags.out_free  = !r_out_valid || !i_stall;
    end

    // Bitmap of struck-out candidates, one write or read per cycle.
    always_ff @(posedge i_clk) begin
        if (ctrl.mem_we) begin
            map_mem[mem_addr] <= ctrl.mem_wd;
        end
        r_rd <= map_mem[mem_addr];
    end

    // Limit, candidate, square, multiple and sum registers.
    always_ff @(posedge i_clk) begin
        if (ctrl.lim_ld) begin
            r_lim <= lim_sat;
        end

        case (ctrl.iop)
            I_TWO: begin
                r_i  <= CNT_W'(2);
                r_sq <= CNT_W'(4);
            end
            I_NEXT: begin
                r_i  <= r_i + CNT_W'(1);
                r_sq <= r_sq + {r_i[CNT_W-2:0], 1'b1};
            end
            default: begin
            end
        endcase

        case (ctrl.jop)
            J_CLR:   r_j <= '0;
            J_INC:   r_j <= r_j + CNT_W'(1);
            J_SQ:    r_j <= r_sq;
            J_ADD_I: r_j <= r_j + r_i;
            default: begin
            end
        endcase

        case (ctrl.sop)
            S_CLR: r_sum <= '0;
            S_ADD_PRIME: begin
                if (!r_rd) begin
                    r_sum <= r_sum + SUM_W'(r_i);
                end
            end
            default: begin
            end
        endcase

        if (ctrl.out_ld) begin
            r_out_sum <= r_sum;
        end
    end

    // Output register holds the result until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall     = !ctrl.in_rdy;
    assign o_valid     = r_out_valid;
    assign o_prime_sum = r_out_sum;

endmodule

// ===== hw/rtl/sps_checker.sv =====
`include "sieve_prime_sum_unit_macros.svh"

module sps_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [sps_pkg::IN_W-1:0]  i_upper_limit,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [sps_pkg::SUM_W-1:0] o_prime_sum
);

    // A stalled result stays valid and unchanged.
    `SPS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_prime_sum))

    // A stalled request stays valid and unchanged.
    `SPS_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_upper_limit))

    // Once a transaction is taken the unit is busy in the next cycle.
    `SPS_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)

    // A result never appears in the cycle right after a transaction is taken.
    `SPS_ASSERT_NEXT(a_no_instant_result, i_valid && !o_stall, !$rose(o_valid))

    // A new result is produced only at the end of a busy period.
    `SPS_ASSERT_NOW(a_result_from_busy, $rose(o_valid), $past(o_stall))

endmodule

bind sieve_prime_sum_unit sps_checker u_sps_checker (.*);
